FILE: design/mac_pkg.sv
// Shared types and constants for the memory admission controller.
package mac_pkg;

  localparam int AMT_W = 48;  // byte amounts, cap, prior, estimate, usage
  localparam int SUM_W = 64;  // per-class byte total
  localparam int CNT_W = 32;  // per-class sample count
  localparam int DEN_W = CNT_W + 1;

  localparam logic [AMT_W-1:0] CAP_RESET   = 48'd68719476736;
  localparam logic [AMT_W-1:0] PRIOR_RESET = 48'd21474836480;

  // Item kinds carried on s_tuser
  typedef enum logic [1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SAMPLE  = 2'd2
  } kind_t;

  // Register indexes (paddr bit 3)
  localparam logic REG_MEMORY_CAP     = 1'b0;
  localparam logic REG_PRIOR_ESTIMATE = 1'b1;

endpackage

FILE: design/memory_admission_controller_core.sv
// Top level: memory admission controller with per-class size estimates.
//
// Items arrive on the s_* stream: s_tuser is the kind (acquire, release,
// sample), s_tdata holds the job class and a byte amount. Each item gives
// exactly one result beat on the m_* stream: granted flag, class estimate
// (prior + total) / (1 + count), usage after the item, underflow flag.
// memory_cap and prior_estimate are written over the APB port (64-bit data,
// byte addresses 0 and 8); the user must write them only while the block is
// idle, which the block itself does not enforce.
// One item at a time: an accepted item updates its class entry (ST_LOAD),
// starts the divider (ST_START), runs the bit-serial divider (ST_DIV, one
// quotient bit per cycle) and settles usage (ST_FINISH), and the next item is
// taken only after its result has been registered.
// Results sit in an output register; s_tready rises again while a result
// waits, but the next result is held until the receiver takes the previous.
// After reset the class table is cleared one entry a cycle with s_tready
// low; usage resets to zero, the registers to their default values.
// Configuration writes are taken at any time.
module memory_admission_controller_core #(
  parameter int NUM_CLASSES = 16
) (
  input  logic          clk,
  input  logic          rst,
  // input stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [55:0]   s_tdata,   // [3:0] job_class, [51:4] amount, zero pad
  input  logic [1:0]    s_tuser,   // [1:0] kind
  // result stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // [0] granted, [48:1] estimate,
                                   // [96:49] usage_now, [97] underflow_error, zero pad
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import mac_pkg::*;

  localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int ENT_W = SUM_W + CNT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] clr_idx;

  // configuration registers
  logic [AMT_W-1:0] memory_cap;
  logic [AMT_W-1:0] prior_estimate;

  // item being worked on
  kind_t            kind;
  logic [IDX_W-1:0] cls;
  logic [AMT_W-1:0] amount;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic [AMT_W-1:0] usage_total;

  // class table
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  logic [IDX_W-1:0] wrap_idx [16];

  // divider
  logic             div_start;
  logic [SUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_busy;
  logic [SUM_W-1:0] div_quot;

  logic [SUM_W-1:0] rd_sum;
  logic [CNT_W-1:0] rd_cnt;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] cnt_next;
  logic [SUM_W:0]   num_add;
  logic [AMT_W-1:0] est;
  logic [AMT_W:0]   charge;
  logic             grant;
  logic             s_beat;
  logic             out_free;
  logic [AMT_W-1:0] usage_next;
  logic             res_granted;
  logic             res_uflow;

  // APB register access
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3])
      REG_MEMORY_CAP:     prdata = {16'd0, memory_cap};
      REG_PRIOR_ESTIMATE: prdata = {16'd0, prior_estimate};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_cap     <= CAP_RESET;
      prior_estimate <= PRIOR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3] == REG_MEMORY_CAP) begin
        memory_cap <= pwdata[AMT_W-1:0];
      end else begin
        prior_estimate <= pwdata[AMT_W-1:0];
      end
    end
  end

  // Class index wraps modulo NUM_CLASSES: a constant table over the 16 codes
  for (genvar g = 0; g < 16; g++) begin : g_wrap
    assign wrap_idx[g] = IDX_W'(g % NUM_CLASSES);
  end

  // Input handshake
  assign s_tready  = (state == ST_IDLE);
  assign s_beat    = s_tvalid && s_tready;
  assign ram_raddr = wrap_idx[s_tdata[3:0]];
  assign out_free  = !m_tvalid || m_tready;

  // Sample update with saturation
  assign rd_sum   = ram_rdata[SUM_W-1:0];
  assign rd_cnt   = ram_rdata[ENT_W-1:SUM_W];
  assign sum_add  = {1'b0, rd_sum} + {{(SUM_W-AMT_W+1){1'b0}}, amount};
  assign sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign cnt_next = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;

  // Table writes: clearing pass, or the sample update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cls;
    ram_wdata = {cnt_next, sum_next};
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (state == ST_LOAD && kind == KIND_SAMPLE) begin
      ram_we = 1'b1;
    end
  end

  // Divider operands: saturated prior + total over 1 + count
  assign num_add   = {1'b0, {(SUM_W-AMT_W){1'b0}}, prior_estimate} + {1'b0, sum};
  assign div_num   = num_add[SUM_W] ? '1 : num_add[SUM_W-1:0];
  assign div_den   = {1'b0, cnt} + DEN_W'(1);
  assign div_start = (state == ST_START);

  // Estimate saturated to 48 bits, admission test
  assign est    = (div_quot[SUM_W-1:AMT_W] != '0) ? '1 : div_quot[AMT_W-1:0];
  assign charge = {1'b0, usage_total} + {1'b0, est};
  assign grant  = (est == '0) || (charge <= {1'b0, memory_cap});

  // Result flags and usage after the item
  always_comb begin
    usage_next  = usage_total;
    res_granted = 1'b0;
    res_uflow   = 1'b0;
    case (kind)
      KIND_ACQUIRE: begin
        if (grant) begin
          usage_next  = charge[AMT_W-1:0];
          res_granted = 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (amount > usage_total) begin
          usage_next = '0;
          res_uflow  = 1'b1;
        end else begin
          usage_next = usage_total - amount;
        end
      end
      default: begin
      end
    endcase
  end

  mac_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_CLASSES)
  ) u_class_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Sequencer, usage and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      usage_total <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(NUM_CLASSES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_beat) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (!div_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state       <= ST_IDLE;
            usage_total <= usage_next;
            m_tdata     <= {6'd0, res_uflow, usage_next, est, res_granted};
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item payload capture
  always_ff @(posedge clk) begin
    if (s_beat) begin
      kind   <= kind_t'(s_tuser);
      cls    <= ram_raddr;
      amount <= s_tdata[51:4];
    end
    if (state == ST_LOAD) begin
      sum <= (kind == KIND_SAMPLE) ? sum_next : rd_sum;
      cnt <= (kind == KIND_SAMPLE) ? cnt_next : rd_cnt;
    end
  end

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("item accepted during table clear");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[97]))
    else $error("grant and underflow flagged together");

  a_result_after_divide: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && !div_busy) |=> (state == ST_FINISH))
    else $error("sequencer skipped result stage");

endmodule

FILE: design/mac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mac_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/mac_div.sv
// Radix-2 restoring divider: 64-bit dividend by 33-bit divisor, one bit per cycle.
module mac_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mac_pkg::SUM_W-1:0] dividend,
  input  logic [mac_pkg::DEN_W-1:0] divisor,
  output logic                      busy,
  output logic [mac_pkg::SUM_W-1:0] quotient
);
  import mac_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [SUM_W-1:0]  shreg;   // dividend bits out the top, quotient bits in the bottom
  logic [STEP_W-1:0] step;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic [DEN_W-1:0]  rem_next;

  // One trial subtraction per cycle
  always_comb begin
    trial    = {rem, shreg[SUM_W-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(SUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den   <= divisor;
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[SUM_W-2:0], ge};
    end
  end

  assign quotient = shreg;

endmodule
